### src/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg - shared types and constants of the digraph cipher
// Word layouts, table geometry, result codes and the table cell lookup.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int SYM_W       = 8;
    localparam int ROW_W       = 2;
    localparam int COL_W       = 3;
    localparam int MAX_ROWS    = 4;
    localparam int MAX_COLS    = 8;
    localparam int NUM_WORDS   = 8;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SYM_W-1:0] MARKER   = 8'd42;
    localparam logic [SYM_W-1:0] END_CODE = 8'd0;
    localparam logic [1:0]       COUNT_ONE = 2'd1;
    localparam logic [1:0]       COUNT_TWO = 2'd2;
    localparam logic             OP_ENCRYPT = 1'b0;
    localparam logic             OP_DECRYPT = 1'b1;

    typedef logic [NUM_WORDS-1:0][CFG_W-1:0] t_table;

    localparam t_table TABLE_RESET = {
        32'd1497913415, 32'd1398421323, 32'd1229081940, 32'd843273780,
        32'd1464616530, 32'd1093883216, 32'd1328893508, 32'd1363495480
    };

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] first_symbol;
        logic [SYM_W-1:0] second_symbol;
        logic             single;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0] first_out;
        logic [SYM_W-1:0] second_out;
        logic [1:0]       count;
        logic             not_found;
    } t_out_word;

    typedef struct packed {
        t_kind            kind;
        logic             op;
        logic             found_a;
        logic             found_b;
        logic [ROW_W-1:0] row_a;
        logic [COL_W-1:0] col_a;
        logic [ROW_W-1:0] row_b;
        logic [COL_W-1:0] col_b;
    } t_item;

    function automatic logic [SYM_W-1:0] cell_at(
        input t_table           tbl,
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        logic [CFG_W-1:0] w;
        w = tbl[{r, c[COL_W-1]}];
        return w[{c[COL_W-2:0], 3'b000} +: SYM_W];
    endfunction

endpackage

### src/pdc_table.sv
// ----------------------------------------------------------------------------
// pdc_table - substitution table registers
// Eight 32-bit words written through the configuration port.
// ----------------------------------------------------------------------------
module pdc_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pdc_pkg::CFG_W-1:0]      i_cfg_data,
    output pdc_pkg::t_table                o_table
);

    pdc_pkg::t_table r_table;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table <= pdc_pkg::TABLE_RESET;
        end else if (i_cfg_we) begin
            r_table[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign o_table = r_table;

endmodule

### src/pdc_front.sv
// ----------------------------------------------------------------------------
// pdc_front - input stage
// Accepts a word, classifies it and locates both symbols in the table.
// ----------------------------------------------------------------------------
module pdc_front #(
    parameter int ROWS = pdc_pkg::MAX_ROWS,
    parameter int COLS = pdc_pkg::MAX_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdc_pkg::t_table    i_table,
    input  logic               i_push,
    input  pdc_pkg::t_in_word  i_word,
    output logic               o_full,
    output logic               o_valid,
    output pdc_pkg::t_item     o_item,
    input  logic               i_ready
);

    logic            r_valid;
    pdc_pkg::t_item  r_item;
    pdc_pkg::t_item  n_item;
    logic            take;

    assign o_full = r_valid && !i_ready;
    assign take   = i_push && !o_full;

    always_comb begin
        n_item = '0;
        n_item.op = i_word.op;
        if (i_word.op == pdc_pkg::OP_DECRYPT &&
            (i_word.single || i_word.first_symbol == pdc_pkg::MARKER)) begin
            n_item.kind = pdc_pkg::KIND_END;
        end else if (i_word.single) begin
            n_item.kind = pdc_pkg::KIND_MARK;
        end else begin
            n_item.kind = pdc_pkg::KIND_LOOKUP;
        end
        // row-major scan, last match wins
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                if (pdc_pkg::cell_at(i_table, pdc_pkg::ROW_W'(r), pdc_pkg::COL_W'(c))
                    == i_word.first_symbol) begin
                    n_item.found_a = 1'b1;
                    n_item.row_a   = pdc_pkg::ROW_W'(r);
                    n_item.col_a   = pdc_pkg::COL_W'(c);
                end
                if (pdc_pkg::cell_at(i_table, pdc_pkg::ROW_W'(r), pdc_pkg::COL_W'(c))
                    == i_word.second_symbol) begin
                    n_item.found_b = 1'b1;
                    n_item.row_b   = pdc_pkg::ROW_W'(r);
                    n_item.col_b   = pdc_pkg::COL_W'(c);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### src/pdc_queue.sv
// ----------------------------------------------------------------------------
// pdc_queue - decoupling queue
// Small register FIFO between the lookup stage and the substitution stage.
// ----------------------------------------------------------------------------
module pdc_queue #(
    parameter int DEPTH = pdc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdc_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_valid,
    output pdc_pkg::t_item  o_item,
    input  logic            i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pdc_pkg::t_item     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule

### src/pdc_back.sv
// ----------------------------------------------------------------------------
// pdc_back - substitution stage
// Applies the row, column or rectangle rule, or gives the marker or end code, and holds the result word.
// ----------------------------------------------------------------------------
module pdc_back #(
    parameter int ROWS = pdc_pkg::MAX_ROWS,
    parameter int COLS = pdc_pkg::MAX_COLS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdc_pkg::t_table     i_table,
    input  logic                i_valid,
    input  pdc_pkg::t_item      i_item,
    output logic                o_take,
    output logic                o_empty,
    output pdc_pkg::t_out_word  o_word,
    input  logic                i_pop
);

    logic                        r_valid;
    pdc_pkg::t_out_word          r_word;
    pdc_pkg::t_out_word          n_word;
    logic [pdc_pkg::ROW_W-1:0]   n1r, n2r;
    logic [pdc_pkg::COL_W-1:0]   n1c, n2c;
    logic                        dec;

    function automatic logic [pdc_pkg::COL_W-1:0] col_step(
        input logic [pdc_pkg::COL_W-1:0] v,
        input logic                      back
    );
        if (back) begin
            return (v == '0) ? pdc_pkg::COL_W'(COLS - 1) : v - 1'b1;
        end
        return ({1'b0, v} + 1'b1 >= (pdc_pkg::COL_W + 1)'(COLS)) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [pdc_pkg::ROW_W-1:0] row_step(
        input logic [pdc_pkg::ROW_W-1:0] v,
        input logic                      back
    );
        if (back) begin
            return (v == '0) ? pdc_pkg::ROW_W'(ROWS - 1) : v - 1'b1;
        end
        return ({1'b0, v} + 1'b1 >= (pdc_pkg::ROW_W + 1)'(ROWS)) ? '0 : v + 1'b1;
    endfunction

    assign o_take  = i_valid && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_word  = r_word;
    assign dec     = (i_item.op == pdc_pkg::OP_DECRYPT);

    always_comb begin
        n1r = i_item.row_a;
        n2r = i_item.row_b;
        n1c = i_item.col_b;
        n2c = i_item.col_a;
        if (i_item.row_a == i_item.row_b) begin
            n1c = col_step(i_item.col_a, dec);
            n2c = col_step(i_item.col_b, dec);
        end else if (i_item.col_a == i_item.col_b) begin
            n1c = i_item.col_a;
            n2c = i_item.col_b;
            n1r = row_step(i_item.row_a, dec);
            n2r = row_step(i_item.row_b, dec);
        end
    end

    always_comb begin
        n_word = '0;
        unique case (i_item.kind)
            pdc_pkg::KIND_END: begin
                n_word.first_out = pdc_pkg::END_CODE;
                n_word.count     = pdc_pkg::COUNT_ONE;
            end
            pdc_pkg::KIND_MARK: begin
                n_word.first_out = pdc_pkg::MARKER;
                n_word.count     = pdc_pkg::COUNT_ONE;
            end
            pdc_pkg::KIND_LOOKUP: begin
                n_word.count = pdc_pkg::COUNT_TWO;
                if (!i_item.found_a || !i_item.found_b) begin
                    n_word.not_found = 1'b1;
                end else begin
                    n_word.first_out  = pdc_pkg::cell_at(i_table, n1r, n1c);
                    n_word.second_out = pdc_pkg::cell_at(i_table, n2r, n2c);
                end
            end
            default: begin
                n_word.count = pdc_pkg::COUNT_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_word <= n_word;
        end
    end

`ifndef ASSERT_OFF
    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_word.count == pdc_pkg::COUNT_ONE ||
                     r_word.count == pdc_pkg::COUNT_TWO))
        else $error("result count out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_word.not_found) |->
            (r_word.first_out == pdc_pkg::END_CODE &&
             r_word.count == pdc_pkg::COUNT_TWO))
        else $error("not_found result carries symbols");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_word)))
        else $error("waiting result changed");
`endif

endmodule

### src/playfair_digraph_cipher_4x8_top.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_4x8_top - Playfair-style digraph cipher
// Encrypts or decrypts symbol pairs over a configurable 4x8 table.
// ----------------------------------------------------------------------------
// One pair enters per clock and one result word leaves per clock while the
// output is not stalled. The compares of both symbols against every table
// cell settle before the accepting edge and land in the lookup register, the
// item then waits at the head of the two-entry queue, and the substitution
// rule is applied as it is loaded into the output register. Full rises only
// when the output is stalled long enough to fill the queue. The table must be
// loaded through the write port only while no pair is in flight; the block
// itself does not enforce this.
module playfair_digraph_cipher_4x8_top #(
    parameter int ROWS = pdc_pkg::MAX_ROWS,
    parameter int COLS = pdc_pkg::MAX_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pdc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  pdc_pkg::t_in_word              i_in_word,
    output logic                           empty,
    input  logic                           pop,
    output pdc_pkg::t_out_word             o_out_word
);

    pdc_pkg::t_table  tbl;
    logic             front_valid;
    pdc_pkg::t_item   front_item;
    logic             q_full;
    logic             q_valid;
    pdc_pkg::t_item   q_item;
    logic             back_take;

    pdc_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_table    (tbl)
    );

    pdc_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_table (tbl),
        .i_push  (push),
        .i_word  (i_in_word),
        .o_full  (full),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (!q_full)
    );

    pdc_queue #(
        .DEPTH (pdc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (back_take)
    );

    pdc_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_table (tbl),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_take  (back_take),
        .o_empty (empty),
        .o_word  (o_out_word),
        .i_pop   (pop)
    );

endmodule
